[design/jsu_pkg.sv]
`timescale 1ns / 1ps

package jsu_pkg;

    // Field widths
    localparam int CH_W    = 8;
    localparam int LEN_W   = 8;
    localparam int HEX_W   = 12;
    // Result slots one input character can fill
    localparam int RES_N   = 4;
    localparam int RES_IW  = $clog2(RES_N);
    localparam int RES_CW  = $clog2(RES_N + 1);

    localparam logic [LEN_W-1:0] MAX_LEN_RST = 8'd32;

    // Characters the unescaper looks at
    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_LC_N   = 8'h6E;
    localparam logic [CH_W-1:0] CH_LC_R   = 8'h72;
    localparam logic [CH_W-1:0] CH_LC_T   = 8'h74;
    localparam logic [CH_W-1:0] CH_LC_U   = 8'h75;
    localparam logic [CH_W-1:0] CH_DIG_0  = 8'h30;
    localparam logic [CH_W-1:0] CH_DIG_9  = 8'h39;
    localparam logic [CH_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CH_W-1:0] CH_LC_F   = 8'h66;
    localparam logic [CH_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UC_F   = 8'h46;

    // UTF-8 encoding constants
    localparam logic [15:0]     UTF8_LIM1 = 16'h0080;
    localparam logic [15:0]     UTF8_LIM2 = 16'h0800;
    localparam logic [CH_W-1:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [CH_W-1:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [CH_W-1:0] UTF8_CONT  = 8'h80;
    localparam logic [5:0]      UTF8_MASK  = 6'h3F;

    // One result beat
    typedef struct packed {
        logic [CH_W-1:0]  data_byte;
        logic             byte_valid;
        logic             done_res;
        logic [LEN_W-1:0] length;
        logic             ok;
        logic             last;
    } t_res;

endpackage

[design/jsu_in_if.sv]
`timescale 1ns / 1ps

// Raw character channel
interface jsu_in_if;
    logic                      valid;
    logic                      ready;
    logic                      start_req;
    logic [jsu_pkg::CH_W-1:0]  ch;

    modport source (output valid, output start_req, output ch, input ready);
    modport sink   (input valid, input start_req, input ch, output ready);
endinterface

[design/jsu_out_if.sv]
`timescale 1ns / 1ps

// Unescaped result channel
interface jsu_out_if;
    logic                      valid;
    logic                      ready;
    logic [jsu_pkg::CH_W-1:0]  data_byte;
    logic                      byte_valid;
    logic                      done_res;
    logic [jsu_pkg::LEN_W-1:0] length;
    logic                      ok;
    logic                      last;

    modport source (output valid, output data_byte, output byte_valid, output done_res,
                    output length, output ok, output last, input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input done_res,
                    input length, input ok, input last, output ready);
endinterface

[design/jsu_cfg_if.sv]
`timescale 1ns / 1ps

// Configuration write channel for the buffer size register
interface jsu_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [jsu_pkg::LEN_W-1:0] max_len;

    modport source (output valid, output max_len, input ready);
    modport sink   (input valid, input max_len, output ready);
endinterface

[design/json_string_unescape_utf8.sv]
`timescale 1ns / 1ps

// Channel   Role    Beat contents
// i_in      sink    start_req, ch
// o_res     source  data_byte, byte_valid, done_res, length, ok, last
// i_cfg     sink    max_len (always ready)
//
// Each character is decoded in the cycle it is accepted and its 0 to 4 results
// are loaded into a four-entry result register that drains one beat per cycle while
// o_res is ready. A character with at most one result is taken every cycle while
// o_res is ready; one with more holds i_in, as the result register has one read port.
// The next character is taken in the cycle the last pending result leaves.
// Synchronous reset empties the result register, ends any value and sets max_len to 32.

module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_res,
    jsu_cfg_if.sink    i_cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEXT,
        ST_ESC,
        ST_HEX0,
        ST_HEX1,
        ST_HEX2,
        ST_HEX3
    } t_mode;

    t_mode                          r_mode, n_mode;
    logic [jsu_pkg::LEN_W-1:0]      r_emit, n_emit;
    logic [jsu_pkg::HEX_W-1:0]      r_hex, n_hex;
    logic [jsu_pkg::LEN_W-1:0]      r_max_len;
    logic [jsu_pkg::RES_CW-1:0]     r_left, n_left;
    logic [jsu_pkg::RES_IW-1:0]     r_rd;
    jsu_pkg::t_res                  r_res [jsu_pkg::RES_N];
    jsu_pkg::t_res                  n_res [jsu_pkg::RES_N];

    logic                           in_beat;
    logic                           out_beat;

    // Hex digit decode: bit 4 flags a character that is not a hex digit
    function automatic logic [4:0] hex_val(input logic [jsu_pkg::CH_W-1:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= jsu_pkg::CH_DIG_0 && c <= jsu_pkg::CH_DIG_9) begin
            v = {1'b0, 4'(c - jsu_pkg::CH_DIG_0)};
        end else if (c >= jsu_pkg::CH_LC_A && c <= jsu_pkg::CH_LC_F) begin
            v = {1'b0, 4'(c - jsu_pkg::CH_LC_A + 8'd10)};
        end else if (c >= jsu_pkg::CH_UC_A && c <= jsu_pkg::CH_UC_F) begin
            v = {1'b0, 4'(c - jsu_pkg::CH_UC_A + 8'd10)};
        end
        return v;
    endfunction

    // Handshakes: a new character enters when no result is pending or the last one leaves
    assign in_beat     = i_in.valid && i_in.ready;
    assign out_beat    = o_res.valid && o_res.ready;
    assign i_in.ready  = (r_left == '0) || ((r_left == jsu_pkg::RES_CW'(1)) && o_res.ready);
    assign i_cfg.ready = 1'b1;

    // Decode one character into its results and the next value state
    always_comb begin
        logic [jsu_pkg::LEN_W-1:0]  lim;
        logic [jsu_pkg::CH_W-1:0]   c;
        logic [jsu_pkg::CH_W-1:0]   esc_byte;
        logic [jsu_pkg::RES_CW-1:0] idx;
        logic                       do_text;
        logic                       esc_unknown;
        logic [4:0]                 hv;
        logic [15:0]                code;
        logic [1:0]                 nb;
        logic [jsu_pkg::LEN_W:0]    need;

        c           = i_in.ch;
        lim         = (r_max_len == '0) ? '0 : r_max_len - 8'd1;
        n_mode      = r_mode;
        n_emit      = r_emit;
        n_hex       = r_hex;
        idx         = '0;
        do_text     = 1'b0;
        esc_unknown = 1'b0;
        esc_byte    = jsu_pkg::CH_BSLASH;
        hv          = hex_val(c);
        code        = {r_hex, hv[3:0]};
        nb          = (code < jsu_pkg::UTF8_LIM1) ? 2'd1 :
                      (code < jsu_pkg::UTF8_LIM2) ? 2'd2 : 2'd3;
        need        = '0;
        for (int k = 0; k < jsu_pkg::RES_N; k++) begin
            n_res[k] = '0;
        end

        // Start of a value, which ends at once when the buffer has no room
        if (i_in.start_req) begin
            n_mode = ST_TEXT;
            n_emit = '0;
            if (lim == '0) begin
                n_res[idx[jsu_pkg::RES_IW-1:0]].done_res = 1'b1;
                idx    = idx + 1'b1;
                n_mode = ST_IDLE;
            end
        end

        case (n_mode)
            ST_TEXT: begin
                do_text = 1'b1;
            end
            ST_ESC: begin
                if (c == jsu_pkg::CH_LC_U) begin
                    n_mode = ST_HEX0;
                end else begin
                    if (c == jsu_pkg::CH_LC_N || c == jsu_pkg::CH_LC_R ||
                        c == jsu_pkg::CH_LC_T) begin
                        esc_byte = jsu_pkg::CH_SPACE;
                    end else if (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH ||
                                 c == jsu_pkg::CH_SLASH) begin
                        esc_byte = c;
                    end else begin
                        esc_unknown = 1'b1;
                    end
                    n_res[idx[jsu_pkg::RES_IW-1:0]].data_byte  = esc_byte;
                    n_res[idx[jsu_pkg::RES_IW-1:0]].byte_valid = 1'b1;
                    idx    = idx + 1'b1;
                    n_emit = n_emit + 8'd1;
                    n_mode = ST_TEXT;
                    if (n_emit >= lim) begin
                        n_res[idx[jsu_pkg::RES_IW-1:0]].done_res = 1'b1;
                        n_res[idx[jsu_pkg::RES_IW-1:0]].length   = n_emit;
                        n_res[idx[jsu_pkg::RES_IW-1:0]].ok       = (n_emit != '0);
                        idx    = idx + 1'b1;
                        n_mode = ST_IDLE;
                    end
                    // An unknown escape sends its backslash, then its character as text if still open
                    do_text = esc_unknown && (n_mode == ST_TEXT);
                end
            end
            ST_HEX0, ST_HEX1, ST_HEX2, ST_HEX3: begin
                if (hv[4]) begin
                    n_res[idx[jsu_pkg::RES_IW-1:0]].done_res = 1'b1;
                    n_res[idx[jsu_pkg::RES_IW-1:0]].length   = n_emit;
                    n_res[idx[jsu_pkg::RES_IW-1:0]].ok       = (n_emit != '0);
                    idx    = idx + 1'b1;
                    n_mode = ST_IDLE;
                end else if (n_mode == ST_HEX0) begin
                    n_hex  = {8'd0, hv[3:0]};
                    n_mode = ST_HEX1;
                end else if (n_mode == ST_HEX1) begin
                    n_hex  = {r_hex[7:0], hv[3:0]};
                    n_mode = ST_HEX2;
                end else if (n_mode == ST_HEX2) begin
                    n_hex  = {r_hex[7:0], hv[3:0]};
                    n_mode = ST_HEX3;
                end else begin
                    // Whole UTF-8 sequence must fit, else the value ends
                    need = {1'b0, n_emit} + {7'd0, nb};
                    if (need >= {1'b0, r_max_len}) begin
                        n_res[idx[jsu_pkg::RES_IW-1:0]].done_res = 1'b1;
                        n_res[idx[jsu_pkg::RES_IW-1:0]].length   = n_emit;
                        n_res[idx[jsu_pkg::RES_IW-1:0]].ok       = (n_emit != '0);
                        idx    = idx + 1'b1;
                        n_mode = ST_IDLE;
                    end else begin
                        if (nb == 2'd1) begin
                            n_res[0].data_byte  = code[7:0];
                            n_res[0].byte_valid = 1'b1;
                        end else if (nb == 2'd2) begin
                            n_res[0].data_byte  = jsu_pkg::UTF8_LEAD2 | code[13:6];
                            n_res[0].byte_valid = 1'b1;
                            n_res[1].data_byte  = jsu_pkg::UTF8_CONT |
                                                  {2'b00, code[5:0] & jsu_pkg::UTF8_MASK};
                            n_res[1].byte_valid = 1'b1;
                        end else begin
                            n_res[0].data_byte  = jsu_pkg::UTF8_LEAD3 | {4'h0, code[15:12]};
                            n_res[0].byte_valid = 1'b1;
                            n_res[1].data_byte  = jsu_pkg::UTF8_CONT |
                                                  {2'b00, code[11:6] & jsu_pkg::UTF8_MASK};
                            n_res[1].byte_valid = 1'b1;
                            n_res[2].data_byte  = jsu_pkg::UTF8_CONT |
                                                  {2'b00, code[5:0] & jsu_pkg::UTF8_MASK};
                            n_res[2].byte_valid = 1'b1;
                        end
                        idx    = {1'b0, nb};
                        n_emit = need[jsu_pkg::LEN_W-1:0];
                        n_mode = ST_TEXT;
                        if (n_emit >= lim) begin
                            n_res[idx[jsu_pkg::RES_IW-1:0]].done_res = 1'b1;
                            n_res[idx[jsu_pkg::RES_IW-1:0]].length   = n_emit;
                            n_res[idx[jsu_pkg::RES_IW-1:0]].ok       = (n_emit != '0);
                            idx    = idx + 1'b1;
                            n_mode = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_mode = ST_IDLE;
            end
        endcase

        // Plain text character
        if (do_text) begin
            if (c == jsu_pkg::CH_NUL || c == jsu_pkg::CH_QUOTE) begin
                n_res[idx[jsu_pkg::RES_IW-1:0]].done_res = 1'b1;
                n_res[idx[jsu_pkg::RES_IW-1:0]].length   = n_emit;
                n_res[idx[jsu_pkg::RES_IW-1:0]].ok       = (n_emit != '0);
                idx    = idx + 1'b1;
                n_mode = ST_IDLE;
            end else if (c == jsu_pkg::CH_BSLASH) begin
                n_mode = ST_ESC;
            end else begin
                n_res[idx[jsu_pkg::RES_IW-1:0]].data_byte  = c;
                n_res[idx[jsu_pkg::RES_IW-1:0]].byte_valid = 1'b1;
                idx    = idx + 1'b1;
                n_emit = n_emit + 8'd1;
                n_mode = ST_TEXT;
                if (n_emit >= lim) begin
                    n_res[idx[jsu_pkg::RES_IW-1:0]].done_res = 1'b1;
                    n_res[idx[jsu_pkg::RES_IW-1:0]].length   = n_emit;
                    n_res[idx[jsu_pkg::RES_IW-1:0]].ok       = (n_emit != '0);
                    idx    = idx + 1'b1;
                    n_mode = ST_IDLE;
                end
            end
        end

        // Flag the final result of this character
        if (idx != '0) begin
            n_res[jsu_pkg::RES_IW'(idx - 1'b1)].last = 1'b1;
        end
        n_left = idx;
    end

    // Value state, result count and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ST_IDLE;
            r_emit    <= '0;
            r_max_len <= jsu_pkg::MAX_LEN_RST;
            r_left    <= '0;
            r_rd      <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_len <= i_cfg.max_len;
            end
            if (in_beat) begin
                r_mode <= n_mode;
                r_emit <= n_emit;
                r_left <= n_left;
                r_rd   <= '0;
            end else if (out_beat) begin
                r_left <= r_left - 1'b1;
                r_rd   <= r_rd + 1'b1;
            end
        end
    end

    // Result entries and hex accumulator
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_hex <= n_hex;
            for (int k = 0; k < jsu_pkg::RES_N; k++) begin
                r_res[k] <= n_res[k];
            end
        end
    end

    // Output beat comes from the current read slot
    assign o_res.valid      = (r_left != '0);
    assign o_res.data_byte  = r_res[r_rd].data_byte;
    assign o_res.byte_valid = r_res[r_rd].byte_valid;
    assign o_res.done_res   = r_res[r_rd].done_res;
    assign o_res.length     = r_res[r_rd].length;
    assign o_res.ok         = r_res[r_rd].ok;
    assign o_res.last       = r_res[r_rd].last;

`ifndef SYNTH
    // A character is only taken when no more than one result is still pending.
    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |-> (r_left <= jsu_pkg::RES_CW'(1)))
        else $error("character accepted while results still pending");

    // Pending results never exceed the result register depth.
    a_left_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= jsu_pkg::RES_CW'(jsu_pkg::RES_N))
        else $error("result count overflow");

    // Every beat is either a byte or the closing result, never both.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.byte_valid ^ o_res.done_res))
        else $error("result beat with bad kind");

    // The closing result of a value is always the last one of its character.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.done_res) |-> o_res.last)
        else $error("done result not marked last");

    // A value that has closed leaves the block outside any value.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && n_left != '0 && n_res[jsu_pkg::RES_IW'(n_left - 1'b1)].done_res)
        |=> (r_mode == ST_IDLE))
        else $error("value still active after done");
`endif

endmodule

[tb/tb_json_string_unescape_utf8.sv]
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 8;

    // Decoder modes of the unescaper.
    typedef enum logic [2:0] {
        M_IDLE, M_TEXT, M_ESC, M_HEX0, M_HEX1, M_HEX2, M_HEX3
    } t_mode;

    logic i_clk;
    logic i_rst_n;

    jsu_in_if  in_if ();
    jsu_out_if res_if ();
    jsu_cfg_if cfg_if ();

    json_string_unescape_utf8 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Shadow state of the unescaper.
    t_mode            mode_q;
    logic [HEX_W-1:0] hex_acc;
    logic [LEN_W-1:0] emit_cnt;
    logic [LEN_W-1:0] max_len_q;

    // Beats caused by the current character, and all beats still owed by the block.
    t_res step_beats[$];
    t_res unescaped_q[$];

    int mismatches;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;

    // Clock.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void add_beat(logic [7:0] b, logic bv, logic dn, logic [7:0] len,
                                     logic okv);
        t_res r;
        if (step_beats.size() >= RES_N)
            return;
        r.data_byte  = b;
        r.byte_valid = bv;
        r.done_res   = dn;
        r.length     = len;
        r.ok         = okv;
        r.last       = 1'b0;
        step_beats.push_back(r);
    endfunction

    function automatic logic [LEN_W-1:0] byte_budget();
        return (max_len_q == 0) ? '0 : max_len_q - 1'b1;
    endfunction

    function automatic void close_value();
        add_beat(8'h00, 1'b0, 1'b1, emit_cnt, emit_cnt != 0);
        mode_q = M_IDLE;
    endfunction

    // One byte out; the value closes as soon as the buffer is full.
    function automatic void emit_byte(logic [7:0] b);
        add_beat(b, 1'b1, 1'b0, 8'h00, 1'b0);
        emit_cnt = emit_cnt + 1'b1;
        mode_q   = M_TEXT;
        if (emit_cnt >= byte_budget())
            close_value();
    endfunction

    function automatic void text_char(logic [7:0] c);
        if (c == CH_NUL || c == CH_QUOTE)
            close_value();
        else if (c == CH_BSLASH)
            mode_q = M_ESC;
        else
            emit_byte(c);
    endfunction

    function automatic int nibble_of(logic [7:0] c);
        if (c >= CH_DIG_0 && c <= CH_DIG_9)
            return int'(c - CH_DIG_0);
        if (c >= CH_LC_A && c <= CH_LC_F)
            return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F)
            return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    // Encode a code point as UTF-8; the whole sequence must fit or the value ends.
    function automatic void put_code(logic [15:0] cp);
        int n;
        n = (cp < UTF8_LIM1) ? 1 : ((cp < UTF8_LIM2) ? 2 : 3);
        if (int'(emit_cnt) + n >= int'(max_len_q)) begin
            close_value();
            return;
        end
        if (n == 1) begin
            add_beat(cp[7:0], 1'b1, 1'b0, 8'h00, 1'b0);
        end else if (n == 2) begin
            add_beat(UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b1, 1'b0, 8'h00, 1'b0);
            add_beat(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, 8'h00, 1'b0);
        end else begin
            add_beat(UTF8_LEAD3 | {4'h0, cp[15:12]}, 1'b1, 1'b0, 8'h00, 1'b0);
            add_beat(UTF8_CONT | {2'b00, cp[11:6]}, 1'b1, 1'b0, 8'h00, 1'b0);
            add_beat(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, 8'h00, 1'b0);
        end
        emit_cnt = emit_cnt + n[LEN_W-1:0];
        mode_q   = M_TEXT;
        if (emit_cnt >= byte_budget())
            close_value();
    endfunction

    // Work out the beats that one accepted character causes.
    function automatic void unescape_char(logic start, logic [7:0] c);
        int v;
        step_beats.delete();
        if (start) begin
            mode_q   = M_TEXT;
            emit_cnt = '0;
            if (byte_budget() == 0)
                close_value();
        end
        case (mode_q)
            M_TEXT: begin
                text_char(c);
            end
            M_ESC: begin
                if (c == CH_LC_U) begin
                    mode_q = M_HEX0;
                end else if (c == CH_LC_N || c == CH_LC_R || c == CH_LC_T) begin
                    emit_byte(CH_SPACE);
                end else if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH) begin
                    emit_byte(c);
                end else begin
                    // Unknown escape: the backslash goes out and the character is
                    // then taken as plain text, if the value is still open.
                    emit_byte(CH_BSLASH);
                    if (mode_q == M_TEXT)
                        text_char(c);
                end
            end
            M_HEX0, M_HEX1, M_HEX2, M_HEX3: begin
                v = nibble_of(c);
                if (v < 0) begin
                    close_value();
                end else if (mode_q == M_HEX0) begin
                    hex_acc = {8'h00, v[3:0]};
                    mode_q  = M_HEX1;
                end else if (mode_q != M_HEX3) begin
                    hex_acc = {hex_acc[7:0], v[3:0]};
                    mode_q  = t_mode'(mode_q + 3'd1);
                end else begin
                    put_code({hex_acc, v[3:0]});
                end
            end
            default: begin
                mode_q = M_IDLE;
            end
        endcase
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i])
            unescaped_q.push_back(step_beats[i]);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Result beats are checked first, then the shadow state follows the
    // configuration write and the character taken at this edge.
    always @(posedge i_clk) begin : beat_monitor
        t_res want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (unescaped_q.size() == 0) begin
                    $display("%0t ns: unexpected beat, expected none, actual byte 0x%0h",
                             $time, res_if.data_byte,
                             " valid %0b done %0b length %0d ok %0b last %0b",
                             res_if.byte_valid, res_if.done_res, res_if.length,
                             res_if.ok, res_if.last);
                    mismatches++;
                end else begin
                    want = unescaped_q.pop_front();
                    check_field("data_byte", want.data_byte, res_if.data_byte);
                    check_field("byte_valid", want.byte_valid, res_if.byte_valid);
                    check_field("done_res", want.done_res, res_if.done_res);
                    check_field("length", want.length, res_if.length);
                    check_field("ok", want.ok, res_if.ok);
                    check_field("last", want.last, res_if.last);
                end
            end
            if (cfg_if.valid && cfg_if.ready)
                max_len_q = cfg_if.max_len;
            if (in_if.valid && in_if.ready)
                unescape_char(in_if.start_req, in_if.ch);
        end
    end

    // Run time limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_request > 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_request - 1;
            hold_request = 0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one character beat; each cycle the sender may idle first.
    task automatic send_char(input logic start, input logic [7:0] c);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.start_req <= start;
        in_if.ch        <= c;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_text(input string s, input logic start);
        for (int i = 0; i < s.len(); i++)
            send_char(start && i == 0, s[i]);
    endtask

    // Let the block drain completely before a register write or the end.
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (unescaped_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_max_len(input logic [LEN_W-1:0] v);
        settle();
        @(negedge i_clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.max_len <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] known_escape();
        case ($urandom_range(5))
            0:       return CH_LC_N;
            1:       return CH_LC_R;
            2:       return CH_LC_T;
            3:       return CH_QUOTE;
            4:       return CH_BSLASH;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 10)
            return CH_DIG_0 + nib;
        return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + (nib - 4'd10);
    endfunction

    function automatic logic [7:0] bad_hex_char();
        logic [7:0] c;
        int         pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return CH_QUOTE;
        if (pick < 5)
            return CH_NUL;
        do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
        return c;
    endfunction

    // Send one character of a random value; the first one carries start_req.
    task automatic send_part(inout logic first, input logic [7:0] c, inout int sent);
        send_char(first, c);
        first = 1'b0;
        sent++;
    endtask

    // A mostly well-formed value with random content, sometimes broken.
    task automatic send_random_value(inout int sent);
        logic        first;
        int          pick;
        int          digits;
        logic [15:0] cp;
        first = 1'b1;
        repeat ($urandom_range(0, 8)) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_part(first, plain_char(), sent);
            end else if (pick < 60) begin
                send_part(first, CH_BSLASH, sent);
                send_part(first, known_escape(), sent);
            end else if (pick < 68) begin
                // Any character after a backslash, NUL and quote included.
                send_part(first, CH_BSLASH, sent);
                send_part(first, 8'($urandom_range(0, 255)), sent);
            end else if (pick < 88) begin
                case ($urandom_range(2))
                    0:       cp = 16'($urandom_range(0, 16'h007F));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                send_part(first, CH_BSLASH, sent);
                send_part(first, CH_LC_U, sent);
                for (int k = 3; k >= 0; k--)
                    send_part(first, hex_char(cp[4*k +: 4]), sent);
            end else if (pick < 95) begin
                send_part(first, CH_BSLASH, sent);
                send_part(first, CH_LC_U, sent);
                digits = $urandom_range(0, 3);
                repeat (digits)
                    send_part(first, hex_char(4'($urandom_range(0, 15))), sent);
                send_part(first, bad_hex_char(), sent);
            end else begin
                // Restart in the middle of the value.
                first = 1'b1;
            end
        end
        pick = $urandom_range(9);
        if (pick < 7)
            send_part(first, CH_QUOTE, sent);
        else if (pick < 9)
            send_part(first, CH_NUL, sent);
        // Stray characters after the value are mostly ignored by the block.
        if ($urandom_range(9) < 2) begin
            repeat ($urandom_range(1, 3))
                send_char(1'b0, 8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_idle_chars();
        send_char(1'b0, "A");
        send_char(1'b0, CH_NUL);
    endtask

    task automatic test_escapes();
        send_text("\\n\\r\\t\\/\\x\\", 1'b1);
        send_char(1'b0, CH_NUL);
        send_text("\\\"\\\\\\u20aC\\u00E9\"", 1'b1);
    endtask

    task automatic test_restart_and_bad_hex();
        send_text("\\u4", 1'b1);
        send_text("q", 1'b1);
        send_text("\\u\"", 1'b0);
    endtask

    task automatic test_tiny_buffer();
        apply_max_len(8'd0);
        send_char(1'b1, "a");
        send_char(1'b0, "b");
        send_char(1'b1, CH_NUL);
        apply_max_len(8'd1);
        send_char(1'b1, "a");
        send_char(1'b0, CH_QUOTE);
    endtask

    task automatic test_buffer_full();
        apply_max_len(8'd4);
        send_text("abcd", 1'b1);
        send_text("a\\u00e9\"", 1'b1);
        send_text("\\u0041\\u20AC\"", 1'b1);
    endtask

    task automatic test_random_values(input logic [LEN_W-1:0] len, input int count);
        int sent;
        apply_max_len(len);
        sent = 0;
        while (sent < count)
            send_random_value(sent);
    endtask

    // The receiver stalls for a long stretch while characters keep coming.
    task automatic test_output_backpressure();
        apply_max_len(8'd255);
        hold_request = 150;
        send_text("\\u20ACxy", 1'b1);
        repeat (11)
            send_text("\\u07ffxy\\n", 1'b0);
        send_char(1'b0, CH_QUOTE);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        mismatches    = 0;
        cycles        = 0;
        hold_request  = 0;
        hold_left     = 0;
        mode_q        = M_IDLE;
        hex_acc       = '0;
        emit_cnt      = '0;
        max_len_q     = MAX_LEN_RST;
        set_idling(19, 54);

        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.start_req  = 1'b0;
        in_if.ch         = '0;
        res_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.max_len   = MAX_LEN_RST;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_chars();
        test_escapes();
        test_restart_and_bad_hex();
        test_tiny_buffer();
        test_buffer_full();
        test_random_values(8'd255, 50);
        test_random_values(8'd7, 40);

        set_idling(54, 19);
        test_random_values(8'd3, 30);
        test_random_values(8'd2, 20);
        test_random_values(8'd20, 40);

        set_idling(0, 0);
        test_output_backpressure();
        test_random_values(8'd12, 40);
        test_random_values(8'd255, 40);

        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
